@@ rtl/extended_tickless_deadline_timer_macros.svh @@
// Assertion macros shared by the timer RTL files.
`ifndef EXTENDED_TICKLESS_DEADLINE_TIMER_MACROS_SVH
`define EXTENDED_TICKLESS_DEADLINE_TIMER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ETDT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("timer assertion failed");

// Next-cycle implication, disabled during reset.
`define ETDT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("timer assertion failed");

`endif

@@ rtl/etdt_pkg.sv @@
// Package with the widths, reset values, codes and types of the deadline timer.
`default_nettype none
package etdt_pkg;
    localparam int COUNTER_BITS_DEF = 24;
    localparam int TIME_W           = 64;
    localparam int MIN_LEAD_W       = 16;
    localparam int OFFSET_W         = 8;
    localparam int CFG_IDX_W        = 8;
    localparam int CFG_DATA_W       = 16;

    localparam logic [MIN_LEAD_W-1:0] MIN_LEAD_RST = 16'd100;
    localparam logic [OFFSET_W-1:0]   OFFSET_RST   = 8'd10;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_LEAD         = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPROGRAM_OFFSET = 8'd1;

    typedef logic [1:0] t_status;
    localparam t_status ST_NONE     = 2'd0;
    localparam t_status ST_ACCEPTED = 2'd1;
    localparam t_status ST_REJECTED = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] match;
        t_status           status;
        logic              tick;
    } t_step;
endpackage
`default_nettype wire

@@ rtl/etdt_if.sv @@
// Channel interfaces of the deadline timer: input words, result words and register writes.
`default_nettype none
interface etdt_in_if;
    import etdt_pkg::*;
    logic              valid;
    logic              ready;
    logic              advance;
    logic              reprogram;
    logic [TIME_W-1:0] deadline;
    logic              start_match;
    modport source (output valid, advance, reprogram, deadline, start_match, input ready);
    modport sink (input valid, advance, reprogram, deadline, start_match, output ready);
endinterface

interface etdt_out_if;
    import etdt_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [TIME_W-1:0] absolute_time;
    logic signed [TIME_W-1:0] time_since_match;
    logic [1:0]               reprogram_status;
    logic                     tick_event;
    modport source (output valid, absolute_time, time_since_match, reprogram_status,
                    tick_event, input ready);
    modport sink (input valid, absolute_time, time_since_match, reprogram_status,
                  tick_event, output ready);
endinterface

interface etdt_cfg_if;
    import etdt_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/etdt_core.sv @@
// Time state of the deadline timer and its combinational update, registered per accepted word.
`default_nettype none
`include "extended_tickless_deadline_timer_macros.svh"
module etdt_core #(
    parameter int COUNTER_BITS = etdt_pkg::COUNTER_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_accept,
    input  wire logic                              i_advance,
    input  wire logic                              i_reprogram,
    input  wire logic [etdt_pkg::TIME_W-1:0]       i_deadline,
    input  wire logic                              i_start_match,
    input  wire logic [etdt_pkg::MIN_LEAD_W-1:0]   i_min_lead,
    input  wire logic [etdt_pkg::OFFSET_W-1:0]     i_offset,
    output etdt_pkg::t_step                        o_step
);
    import etdt_pkg::*;

    // The current time is kept directly; the counter expires where it would reach zero.
    logic [TIME_W-1:0]       r_now;
    logic [COUNTER_BITS-1:0] r_counter;
    logic [TIME_W-1:0]       r_match;

    logic [TIME_W-1:0]       n_now;
    logic [COUNTER_BITS-1:0] n_counter;
    logic [TIME_W-1:0]       n_match;
    t_status                 n_status;
    logic                    n_tick;

    logic                    cnt_zero;
    logic                    inc;
    logic [COUNTER_BITS-1:0] counter_a;
    logic [TIME_W-1:0]       now_a;
    logic [TIME_W-1:0]       start_time;
    logic [TIME_W-1:0]       delta;
    logic                    too_close;

    always_comb begin
        cnt_zero   = (r_counter == '0);
        inc        = i_advance && !cnt_zero;
        n_tick     = i_advance && cnt_zero;
        counter_a  = !i_advance ? r_counter : (cnt_zero ? '1 : r_counter - 1'b1);
        now_a      = r_now + {{(TIME_W-1){1'b0}}, inc};
        start_time = r_now + {{(TIME_W-OFFSET_W){1'b0}}, i_offset}
                     + {{(TIME_W-1){1'b0}}, inc};
        delta      = i_deadline - start_time;
        too_close  = delta[TIME_W-1]
                     || ((delta[TIME_W-2:MIN_LEAD_W] == '0)
                         && (delta[MIN_LEAD_W-1:0] < i_min_lead));

        n_now     = now_a;
        n_counter = counter_a;
        n_status  = ST_NONE;
        if (i_reprogram) begin
            if (too_close) begin
                n_status = ST_REJECTED;
            end else begin
                n_status  = ST_ACCEPTED;
                n_now     = start_time;
                n_counter = delta[COUNTER_BITS-1:0];
            end
        end

        n_match = r_match;
        if (i_start_match && (r_match == '0)) begin
            n_match = n_now;
        end

        o_step.now    = n_now;
        o_step.match  = n_match;
        o_step.status = n_status;
        o_step.tick   = n_tick;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now     <= {{(TIME_W-COUNTER_BITS){1'b0}}, {COUNTER_BITS{1'b1}}};
            r_counter <= '0;
            r_match   <= '0;
        end else if (i_accept) begin
            r_now     <= n_now;
            r_counter <= n_counter;
            r_match   <= n_match;
        end
    end

    `ETDT_ASSERT_NEXT(a_hold_when_idle, i_clk, i_rst_n, !i_accept,
        $stable(r_now) && $stable(r_counter) && $stable(r_match))
    `ETDT_ASSERT_NEXT(a_time_steps_by_one, i_clk, i_rst_n, i_accept && !i_reprogram,
        (r_now - $past(r_now)) <= {{(TIME_W-1){1'b0}}, 1'b1})
    `ETDT_ASSERT_NEXT(a_counter_hits_deadline, i_clk, i_rst_n,
        i_accept && (n_status == ST_ACCEPTED),
        r_counter == ($past(i_deadline[COUNTER_BITS-1:0]) - r_now[COUNTER_BITS-1:0]))
endmodule
`default_nettype wire

@@ rtl/extended_tickless_deadline_timer.sv @@
// Top level of the 64-bit extended tickless deadline timer.
// The timer takes one input word per clock cycle while its input is ready and gives exactly one
// result word for each, through a stage register and then an output register; the rate of one
// word per cycle is set by the combinational update of the time state (one increment, the
// deadline subtraction and the lead compare), and the stage register plus the output register
// keep the input open while a finished result waits. Register writes are taken in any
// cycle, with the configuration channel always ready.
`default_nettype none
`include "extended_tickless_deadline_timer_macros.svh"
module extended_tickless_deadline_timer #(
    parameter int COUNTER_BITS = etdt_pkg::COUNTER_BITS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    etdt_in_if.sink     i_in,
    etdt_out_if.source  o_out,
    etdt_cfg_if.sink    i_cfg
);
    import etdt_pkg::*;

    logic [MIN_LEAD_W-1:0] r_min_lead;
    logic [OFFSET_W-1:0]   r_offset;

    t_step                 step;
    logic                  accept;
    logic                  out_free;

    t_step                 r_p;
    logic                  r_p_valid;
    logic                  r_o_valid;
    logic [TIME_W-1:0]     r_o_abs;
    logic [TIME_W-1:0]     r_o_since;
    t_status               r_o_status;
    logic                  r_o_tick;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_lead <= MIN_LEAD_RST;
            r_offset   <= OFFSET_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_MIN_LEAD: begin
                    r_min_lead <= i_cfg.data[MIN_LEAD_W-1:0];
                end
                REG_REPROGRAM_OFFSET: begin
                    r_offset <= i_cfg.data[OFFSET_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign out_free   = !r_o_valid || o_out.ready;
    assign i_in.ready = !r_p_valid || out_free;
    assign accept     = i_in.valid && i_in.ready;

    etdt_core #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_advance     (i_in.advance),
        .i_reprogram   (i_in.reprogram),
        .i_deadline    (i_in.deadline),
        .i_start_match (i_in.start_match),
        .i_min_lead    (r_min_lead),
        .i_offset      (r_offset),
        .o_step        (step)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_p_valid <= 1'b1;
            end else if (out_free) begin
                r_p_valid <= 1'b0;
            end
            if (out_free) begin
                r_o_valid <= r_p_valid;
            end
        end
        if (accept) begin
            r_p <= step;
        end
        if (out_free && r_p_valid) begin
            r_o_abs    <= r_p.now;
            r_o_since  <= r_p.now - r_p.match;
            r_o_status <= r_p.status;
            r_o_tick   <= r_p.tick;
        end
    end

    assign o_out.valid            = r_o_valid;
    assign o_out.absolute_time    = signed'(r_o_abs);
    assign o_out.time_since_match = signed'(r_o_since);
    assign o_out.reprogram_status = r_o_status;
    assign o_out.tick_event       = r_o_tick;

    `ETDT_ASSERT_NOW(a_full_pipe_blocks_input, i_clk, i_rst_n,
        r_p_valid && r_o_valid && !o_out.ready, !i_in.ready)
    `ETDT_ASSERT_NEXT(a_stage_moves_forward, i_clk, i_rst_n,
        r_p_valid && out_free, r_o_valid)
    `ETDT_ASSERT_NEXT(a_status_reaches_output, i_clk, i_rst_n,
        r_p_valid && out_free, r_o_status == $past(r_p.status))
endmodule
`default_nettype wire
